[sv/kbdq_pkg.sv]
// ----------------------------------------------------------------------------
// kbdq_pkg
// Types, codes and default constants shared by the key decision queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kbdq_pkg;

	localparam int KEY_W              = 8;
	localparam int QUEUE_DEPTH_DEF    = 16;
	localparam int DEVICE_ID_BITS_DEF = 16;
	localparam int SRC_DEV_W          = 16;

	localparam logic [KEY_W-1:0] LATCH_KEY_RESET = 8'd13;

	localparam logic CMD_RAW  = 1'b0;
	localparam logic CMD_HOOK = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             block;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

	typedef struct packed {
		logic shift;
		logic tail_new;
		logic load;
	} chain_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} kbdq_state_t;

endpackage

[sv/kbdq_cell.sv]
// ----------------------------------------------------------------------------
// kbdq_cell
// One queue cell: holds an entry, takes a new one or its neighbour's.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbdq_cell
	import kbdq_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  entry_t     nb_in,
	input  entry_t     load_in,
	output entry_t     entry
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			entry_q <= load_in;
		end else if (ctrl.shift) begin
			entry_q <= nb_in;
		end
	end

	assign entry = entry_q;

endmodule

[sv/kbdq_chain.sv]
// ----------------------------------------------------------------------------
// kbdq_chain
// Ring of cells, oldest entry at head, shifting one place a cycle on shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbdq_chain
	import kbdq_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  chain_ctrl_t      ctrl,
	input  logic [IDX_W-1:0] load_idx,
	input  entry_t           new_entry,
	output entry_t           head
);

	entry_t     cell_q [DEPTH];
	entry_t     nb     [DEPTH];
	cell_ctrl_t cctrl  [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_tail
			assign nb[i] = ctrl.tail_new ? new_entry : cell_q[0];
		end else begin : g_body
			assign nb[i] = cell_q[i+1];
		end

		assign cctrl[i].shift = ctrl.shift;
		assign cctrl[i].load  = ctrl.load && (load_idx == IDX_W'(i));

		kbdq_cell u_cell (
			.clk     (clk),
			.ctrl    (cctrl[i]),
			.nb_in   (nb[i]),
			.load_in (new_entry),
			.entry   (cell_q[i])
		);
	end

	assign head = cell_q[0];

endmodule

[sv/key_block_decision_queue.sv]
// ----------------------------------------------------------------------------
// key_block_decision_queue
// Pairs raw key events with hook events and reports block decisions. A raw
// key-down transaction latches the device or appends a key code with its
// decision to a queue of QUEUE_DEPTH cells, dropping the oldest entry when
// the queue is full. A hook transaction with the key released goes
// straight to the done state; one with the key pressed first runs a search,
// which rotates the ring of cells one place per cycle and examines the head
// cell each time until a hit or the last cell. The output register lets a
// result wait for the consumer while the next transaction is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_block_decision_queue
	import kbdq_pkg::*;
#(
	parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
	parameter int DEVICE_ID_BITS = DEVICE_ID_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [KEY_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic                 key_down,
	input  logic [KEY_W-1:0]     key_code,
	input  logic [SRC_DEV_W-1:0] source_device,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 block_key,
	output logic                 match_found
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	kbdq_state_t state_q, state_d;

	logic [KEY_W-1:0]          latch_key_q;
	logic                      device_latched_q;
	logic [DEVICE_ID_BITS-1:0] latched_dev_q;
	logic [CNT_W-1:0]          count_q;
	logic [IDX_W-1:0]          step_q;
	logic [CNT_W-1:0]          drop_q;
	logic [KEY_W-1:0]          key_q;
	logic                      found_q;
	logic                      block_q;
	logic                      out_valid_q;
	logic                      block_key_q;
	logic                      match_found_q;

	logic                              accept;
	logic                              raw_down;
	logic                              latch_hit;
	logic                              enqueue;
	logic                              full;
	logic                              hit;
	logic                              last_step;
	logic                              out_free;
	logic [DEVICE_ID_BITS+SRC_DEV_W-1:0] dev_ext;
	logic [DEVICE_ID_BITS-1:0]         dev;
	chain_ctrl_t                       chain_ctrl;
	entry_t                            new_entry;
	entry_t                            head;

	assign accept    = in_valid && in_ready;
	assign raw_down  = accept && (cmd == CMD_RAW) && key_down;
	assign latch_hit = raw_down && !device_latched_q && (key_code == latch_key_q);
	assign enqueue   = raw_down && !latch_hit;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign dev_ext   = {{DEVICE_ID_BITS{1'b0}}, source_device};
	assign dev       = dev_ext[DEVICE_ID_BITS-1:0];
	assign hit       = (head.key == key_q) && (CNT_W'(step_q) < count_q);
	assign last_step = (step_q == IDX_W'(QUEUE_DEPTH - 1));
	assign out_free  = !out_valid_q || out_ready;

	assign new_entry.key   = key_code;
	assign new_entry.block = device_latched_q && (latched_dev_q == dev);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_HOOK)) begin
					state_d = key_down ? ST_SEARCH : ST_DONE;
				end
			end
			ST_SEARCH: begin
				if (hit || last_step) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready            = 1'b0;
		chain_ctrl.shift    = 1'b0;
		chain_ctrl.tail_new = 1'b0;
		chain_ctrl.load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready            = 1'b1;
				chain_ctrl.shift    = enqueue && full;
				chain_ctrl.tail_new = enqueue && full;
				chain_ctrl.load     = enqueue && !full;
			end
			ST_SEARCH: begin
				chain_ctrl.shift = 1'b1;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	kbdq_chain #(
		.DEPTH (QUEUE_DEPTH)
	) u_chain (
		.clk       (clk),
		.ctrl      (chain_ctrl),
		.load_idx  (count_q[IDX_W-1:0]),
		.new_entry (new_entry),
		.head      (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			latch_key_q      <= LATCH_KEY_RESET;
			device_latched_q <= 1'b0;
			latched_dev_q    <= '0;
			count_q          <= '0;
			step_q           <= '0;
			found_q          <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				latch_key_q <= cfg_wdata;
			end
			if (latch_hit) begin
				device_latched_q <= 1'b1;
				latched_dev_q    <= dev;
			end
			if (enqueue && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (state_q == ST_IDLE) begin
				step_q  <= '0;
				found_q <= 1'b0;
			end else if (state_q == ST_SEARCH) begin
				step_q <= step_q + IDX_W'(1);
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
				if (found_q) begin
					count_q <= count_q - drop_q;
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key_code;
		end
		if ((state_q == ST_SEARCH) && hit) begin
			block_q <= head.block;
			drop_q  <= CNT_W'(step_q) + CNT_W'(1);
		end
		if ((state_q == ST_DONE) && out_free) begin
			block_key_q   <= found_q && block_q;
			match_found_q <= found_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign block_key   = block_key_q;
	assign match_found = match_found_q;

endmodule

[sv/kbdq_checker.sv]
// ----------------------------------------------------------------------------
// kbdq_checker
// Port-level checks on the key decision queue, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbdq_checker
	import kbdq_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 cmd,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 block_key,
	input logic                 match_found
);

	// A taken hook transaction always drops in_ready, keeping the block busy.
	a_hook_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_HOOK) |=> !in_ready)
		else $error("in_ready high in the cycle after a hook transaction");

	// A raw transaction completes in the cycle it is taken.
	a_raw_single: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_RAW) |=> in_ready)
		else $error("in_ready low in the cycle after a raw transaction");

	// A block decision is only reported for a matched entry.
	a_block_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && block_key |-> match_found)
		else $error("block_key set without match_found");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(block_key) && $stable(match_found))
		else $error("result changed while stalled");

endmodule

bind key_block_decision_queue kbdq_checker u_kbdq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.cmd         (cmd),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.block_key   (block_key),
	.match_found (match_found)
);

[tb/key_block_decision_queue_tb.sv]
// ----------------------------------------------------------------------------
// key_block_decision_queue_tb
// Self-checking testbench for the key block decision queue. A clocked driver
// feeds raw and hook key events from a queue of pending transactions, and a
// clocked monitor compares every result with the oldest predicted verdict.
// The prediction keeps its own copy of the latch state and the key queue.
// Directed events cover latching, release events, matches, misses and queue
// overflow. Random phases under several latch key settings follow, with
// random idling on both sides, a long receiver stall and a final phase with
// no idling at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_block_decision_queue_tb;
	import kbdq_pkg::*;

	typedef struct packed {
		logic                 cmd;
		logic                 key_down;
		logic [KEY_W-1:0]     key_code;
		logic [SRC_DEV_W-1:0] source_device;
	} key_event_t;

	typedef struct packed {
		logic block_key;
		logic match_found;
	} verdict_t;

	localparam logic [SRC_DEV_W-1:0] BLOCKED_DEV = 16'hA5A5;
	localparam int                   IDLE_LIMIT  = 2000;
	localparam int                   LONG_STALL  = 300;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 cfg_we        = 1'b0;
	logic [KEY_W-1:0]     cfg_wdata     = '0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic                 cmd           = 1'b0;
	logic                 key_down      = 1'b0;
	logic [KEY_W-1:0]     key_code      = '0;
	logic [SRC_DEV_W-1:0] source_device = '0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic                 block_key;
	logic                 match_found;

	key_event_t pending_events[$];
	verdict_t   expected_verdicts[$];

	logic [KEY_W-1:0]     model_latch_key = LATCH_KEY_RESET;
	logic                 model_latched   = 1'b0;
	logic [SRC_DEV_W-1:0] model_device    = '0;
	entry_t               model_entries[$];

	int errors       = 0;
	int send_gap     = 0;
	int recv_hold    = 0;
	int stall_req    = 0;
	int stall_seen   = 0;
	int idle_cycles  = 0;
	bit quiet        = 1'b0;

	key_block_decision_queue u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.key_down     (key_down),
		.key_code     (key_code),
		.source_device(source_device),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.block_key    (block_key),
		.match_found  (match_found)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic predict_decision(input key_event_t ev);
		entry_t   ent;
		verdict_t v;
		int       hit;
		if (ev.cmd == CMD_RAW) begin
			if (ev.key_down) begin
				if (!model_latched && ev.key_code == model_latch_key) begin
					model_latched = 1'b1;
					model_device  = ev.source_device;
				end else begin
					ent.key   = ev.key_code;
					ent.block = model_latched && (model_device == ev.source_device);
					if (model_entries.size() >= QUEUE_DEPTH_DEF)
						model_entries.delete(0);
					model_entries = {model_entries, ent};
				end
			end
		end else begin
			v   = '0;
			hit = -1;
			if (ev.key_down) begin
				foreach (model_entries[i])
					if (hit < 0 && model_entries[i].key == ev.key_code)
						hit = i;
				if (hit >= 0) begin
					v.block_key   = model_entries[hit].block;
					v.match_found = 1'b1;
					repeat (hit + 1) model_entries.delete(0);
				end
			end
			expected_verdicts = {expected_verdicts, v};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid      <= 1'b0;
			cmd           <= 1'b0;
			key_down      <= 1'b0;
			key_code      <= '0;
			source_device <= '0;
		end else begin
			if (in_valid && in_ready)
				predict_decision({cmd, key_down, key_code, source_device});
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap = send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_events.size() == 0) begin
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(1, 9) - 1;
					in_valid <= 1'b0;
				end else begin
					{cmd, key_down, key_code, source_device} <= pending_events[0];
					pending_events.delete(0);
					in_valid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("result with no expected verdict: block_key %0b match_found %0b",
						block_key, match_found);
					errors = errors + 1;
				end else begin
					verdict_t v;
					v = expected_verdicts[0];
					expected_verdicts.delete(0);
					if (block_key !== v.block_key) begin
						$error("block_key expected %0b actual %0b", v.block_key, block_key);
						errors = errors + 1;
					end
					if (match_found !== v.match_found) begin
						$error("match_found expected %0b actual %0b", v.match_found,
							match_found);
						errors = errors + 1;
					end
				end
			end
			if (stall_seen != stall_req) begin
				stall_seen = stall_req;
				recv_hold  = LONG_STALL;
				out_ready <= 1'b0;
			end else if (recv_hold > 0) begin
				recv_hold = recv_hold - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				recv_hold = $urandom_range(1, 9) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL key_block_decision_queue");
				$finish;
			end
		end
	end

	task automatic queue_event(input logic c, input logic d, input logic [KEY_W-1:0] k,
			input logic [SRC_DEV_W-1:0] dev);
		key_event_t ev;
		ev = {c, d, k, dev};
		pending_events = {pending_events, ev};
	endtask

	task automatic wait_idle();
		while (pending_events.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (QUEUE_DEPTH_DEF + 8) @(posedge clk);
	endtask

	task automatic write_latch_key(input logic [KEY_W-1:0] value);
		@(posedge clk);
		cfg_we          <= 1'b1;
		cfg_wdata       <= value;
		model_latch_key  = value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic gen_random(input int count);
		int               n;
		int               sel;
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] recent[$];
		n = 0;
		while (n < count) begin
			sel = $urandom_range(0, 99);
			if (sel < 35) begin
				if ($urandom_range(0, 1) == 0)
					k = KEY_W'($urandom_range(0, 7) * 36);
				else
					k = KEY_W'($urandom);
				queue_event(CMD_RAW, 1'b1, k,
					($urandom_range(0, 1) == 0) ? BLOCKED_DEV : SRC_DEV_W'($urandom));
				recent = {recent, k};
				if (recent.size() > QUEUE_DEPTH_DEF)
					recent.delete(0);
				n = n + 1;
			end else if (sel < 50) begin
				queue_event(CMD_RAW, 1'b0, KEY_W'($urandom), SRC_DEV_W'($urandom));
				n = n + 1;
			end else if (sel < 80) begin
				if (recent.size() > 0 && $urandom_range(0, 3) != 0)
					k = recent[$urandom_range(0, recent.size() - 1)];
				else
					k = KEY_W'($urandom);
				queue_event(CMD_HOOK, 1'b1, k, SRC_DEV_W'($urandom));
				n = n + 1;
			end else if (sel < 90) begin
				queue_event(CMD_HOOK, 1'b0, KEY_W'($urandom), SRC_DEV_W'($urandom));
				n = n + 1;
			end else begin
				queue_event(1'($urandom), 1'($urandom), KEY_W'($urandom),
					SRC_DEV_W'($urandom));
				n = n + 1;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Latch key at its reset value; nothing is latched yet.
		queue_event(CMD_HOOK, 1'b1, 8'd0, 16'hFFFF);
		queue_event(CMD_HOOK, 1'b0, 8'd255, 16'h0000);
		queue_event(CMD_RAW, 1'b0, LATCH_KEY_RESET, 16'h0000);
		queue_event(CMD_RAW, 1'b1, 8'd0, 16'h0000);
		queue_event(CMD_RAW, 1'b1, 8'd255, 16'hFFFF);
		queue_event(CMD_HOOK, 1'b1, 8'd255, 16'h0000);
		queue_event(CMD_HOOK, 1'b1, 8'd0, 16'h0000);
		wait_idle();

		write_latch_key(8'd255);
		queue_event(CMD_RAW, 1'b1, LATCH_KEY_RESET, BLOCKED_DEV);
		queue_event(CMD_RAW, 1'b1, 8'd255, BLOCKED_DEV);
		queue_event(CMD_RAW, 1'b1, 8'd255, BLOCKED_DEV);
		queue_event(CMD_RAW, 1'b1, 8'd7, 16'h5A5A);
		for (int i = 0; i < 14; i++)
			queue_event(CMD_RAW, 1'b1, KEY_W'(100 + i), (i % 2 == 0) ? BLOCKED_DEV : 16'h0001);
		queue_event(CMD_HOOK, 1'b1, LATCH_KEY_RESET, 16'h0000);
		queue_event(CMD_HOOK, 1'b1, 8'd106, 16'h0000);
		wait_idle();

		write_latch_key(8'd0);
		gen_random(170);
		wait_idle();

		write_latch_key(KEY_W'($urandom));
		stall_req = stall_req + 1;
		for (int i = 0; i < 12; i++) begin
			queue_event(CMD_RAW, 1'b1, KEY_W'(i), BLOCKED_DEV);
			queue_event(CMD_HOOK, 1'b1, KEY_W'(i), 16'h0000);
		end
		gen_random(150);
		wait_idle();

		write_latch_key(LATCH_KEY_RESET);
		gen_random(170);
		wait_idle();

		quiet = 1'b1;
		write_latch_key(KEY_W'($urandom));
		gen_random(190);
		wait_idle();

		if (errors == 0)
			$display("PASS key_block_decision_queue");
		else
			$display("FAIL key_block_decision_queue");
		$finish;
	end

endmodule
